// ===== hw/rtl/clock_mult_shift_calc_top_defines.svh =====
// Assertion helpers for the checker file cms_checker.sv.
`ifndef CLOCK_MULT_SHIFT_CALC_TOP_DEFINES_SVH
`define CLOCK_MULT_SHIFT_CALC_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CMS_ASSERT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CMS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== hw/rtl/cms_pkg.sv =====
package cms_pkg;

    localparam int WORD_W     = 32;
    localparam int DWORD_W    = 64;
    localparam int SHIFT_W    = 6;
    localparam int SPAN_W     = 10;
    localparam int HEAD_LEN_W = 4;

    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 168;

    localparam logic [SHIFT_W-1:0] MAX_SHIFT  = 6'd32;
    localparam logic [SHIFT_W-1:0] MIN_SHIFT  = 6'd1;
    localparam logic [SHIFT_W-1:0] ROOM_MAX   = 6'd32;
    localparam logic [WORD_W-1:0]  NS_PER_SEC = 32'd1000000000;
    localparam logic [SPAN_W-1:0]  SPAN_CLOCK = 10'd600;
    localparam logic [SPAN_W-1:0]  SPAN_EVENT = 10'd60;

    localparam logic OP_CLOCK = 1'b0;
    localparam logic OP_EVENT = 1'b1;

endpackage

// ===== hw/rtl/cms_div.sv =====
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit divisor.
module cms_div
    import cms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DWORD_W-1:0] dividend,
    input  logic [WORD_W-1:0]  divisor,
    output logic               done,
    output logic [DWORD_W-1:0] quotient
);

    logic               busy_reg;
    logic               done_reg;
    logic [5:0]         cnt_reg;
    logic [DWORD_W-1:0] quot_reg;
    logic [WORD_W-1:0]  rem_reg;
    logic [WORD_W-1:0]  div_reg;

    logic [WORD_W:0]    trial;
    logic [WORD_W:0]    diff;
    logic               ge;

    assign trial = {rem_reg, quot_reg[DWORD_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DWORD_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            // dividend bits shift out the top, quotient bits shift in at the bottom
            quot_reg <= {quot_reg[DWORD_W-2:0], ge};
            rem_reg  <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== hw/rtl/clock_mult_shift_calc_top.sv =====
// Multiplier/shift set-up for a timer. Each request gives a frequency and a direction
// (op 0: ticks to ns over a 600 s span, op 1: ns to ticks over a 60 s span) and yields
// mult and shift for to = (from * mult) >> shift, the tick limit before the product
// overflows (capped by the given limit) and the matching ns limit; a zero multiplier
// sets bad_mult and zeroes both limits. The block takes one request at a time:
// s_tready is high only while idle, and a finished result may wait in the output
// register while the next request is taken. All divisions run on one restoring divider
// at one quotient bit per cycle. With a nonzero given_mult a request runs the cap
// division, then a two-step multiply for op 0 or a second division for op 1; when the
// multiplier is searched, up to 32 trial divisions (shift 32 down to 1) come first.
module clock_mult_shift_calc_top
    import cms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // frequency[31:0], given_mult[63:32], given_shift[69:64], given_max_ticks[133:70]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // scale_mult[31:0], scale_shift[37:32], tick_limit[101:38], ns_limit[165:102]
    output logic [M_TDATA_W-1:0] m_tdata,
    // bad_mult
    output logic                 m_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SRCH_GO,
        ST_SRCH_WAIT,
        ST_CAP_GO,
        ST_CAP_WAIT,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_NS_SUM,
        ST_NSDIV_GO,
        ST_NSDIV_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;

    logic                 op_reg;
    logic [DWORD_W-1:0]   gticks_reg;
    logic [WORD_W-1:0]    from_reg;
    logic [WORD_W-1:0]    to_reg;
    logic [SPAN_W-1:0]    span_reg;
    logic [SHIFT_W-1:0]   room_reg;
    logic [SHIFT_W-1:0]   s_reg;
    logic [WORD_W-1:0]    mult_reg;
    logic [SHIFT_W-1:0]   shift_reg;
    logic [DWORD_W-1:0]   ticks_reg;
    logic [DWORD_W-1:0]   ns_reg;
    logic [DWORD_W-1:0]   acc_reg;
    logic [WORD_W-1:0]    hp_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic [WORD_W-1:0]  in_freq;
    logic [WORD_W-1:0]  in_gmult;
    logic [SHIFT_W-1:0] in_gshift;
    logic [DWORD_W-1:0] in_gticks;

    logic [SPAN_W+WORD_W-1:0] head_prod;
    logic [SPAN_W-1:0]        head;
    logic [HEAD_LEN_W-1:0]    head_len;

    logic               div_start;
    logic [DWORD_W-1:0] div_dividend;
    logic [WORD_W-1:0]  div_divisor;
    logic               div_done;
    logic [DWORD_W-1:0] div_quot;

    logic               fits;
    logic               srch_end;
    logic [DWORD_W-1:0] ticks_cap;
    logic [WORD_W-1:0]  mul_a;
    logic [DWORD_W-1:0] mul_p;
    logic               out_free;

    assign in_freq   = s_tdata[31:0];
    assign in_gmult  = s_tdata[63:32];
    assign in_gshift = s_tdata[69:64];
    assign in_gticks = s_tdata[133:70];

    // overflow headroom: 32 minus the bit length of (span * from) >> 32
    assign head_prod = (SPAN_W+WORD_W)'(span_reg) * (SPAN_W+WORD_W)'(from_reg);
    assign head      = head_prod[SPAN_W+WORD_W-1:WORD_W];

    always_comb
    begin
        head_len = '0;
        for (int i = 0; i < SPAN_W; i++)
        begin
            if (head[i])
                head_len = HEAD_LEN_W'(i + 1);
        end
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = mult_reg;
        unique case (state_reg)
            ST_SRCH_GO:
            begin
                div_start    = 1'b1;
                div_dividend = (DWORD_W'(to_reg) << s_reg) + DWORD_W'(from_reg[WORD_W-1:1]);
                div_divisor  = from_reg;
            end
            ST_CAP_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {DWORD_W{1'b1}};
            end
            ST_NSDIV_GO:
            begin
                div_start    = 1'b1;
                div_dividend = ticks_reg << shift_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    cms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign fits      = (div_quot >> room_reg) == '0;
    assign srch_end  = fits || (s_reg == MIN_SHIFT);
    assign ticks_cap = (gticks_reg != '0 && gticks_reg < div_quot) ? gticks_reg : div_quot;
    assign mul_a     = (state_reg == ST_MUL_LO) ? ticks_reg[WORD_W-1:0]
                                                : ticks_reg[DWORD_W-1:WORD_W];
    assign mul_p     = DWORD_W'(mul_a) * DWORD_W'(mult_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // in ST_FINISH the output valid is handled below
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        priority if (in_gmult != '0)
                            state_reg <= ST_CAP_GO;
                        else if (s_tuser == OP_CLOCK && in_freq == '0)
                            state_reg <= ST_FINISH;
                        else
                            state_reg <= ST_HEAD;
                    end
                end
                ST_HEAD:      state_reg <= ST_SRCH_GO;
                ST_SRCH_GO:   state_reg <= ST_SRCH_WAIT;
                ST_SRCH_WAIT:
                begin
                    if (div_done)
                    begin
                        priority if (!srch_end)
                            state_reg <= ST_SRCH_GO;
                        else if (div_quot[WORD_W-1:0] == '0)
                            state_reg <= ST_FINISH;
                        else
                            state_reg <= ST_CAP_GO;
                    end
                end
                ST_CAP_GO:    state_reg <= ST_CAP_WAIT;
                ST_CAP_WAIT:
                begin
                    if (div_done)
                        state_reg <= (op_reg == OP_CLOCK) ? ST_MUL_LO : ST_NSDIV_GO;
                end
                ST_MUL_LO:    state_reg <= ST_MUL_HI;
                ST_MUL_HI:    state_reg <= ST_NS_SUM;
                ST_NS_SUM:    state_reg <= ST_FINISH;
                ST_NSDIV_GO:  state_reg <= ST_NSDIV_WAIT;
                ST_NSDIV_WAIT:
                begin
                    if (div_done)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_reg     <= s_tuser;
                    gticks_reg <= in_gticks;
                    ticks_reg  <= '0;
                    ns_reg     <= '0;
                    s_reg      <= MAX_SHIFT;
                    if (s_tuser == OP_EVENT)
                    begin
                        from_reg <= NS_PER_SEC;
                        to_reg   <= in_freq;
                        span_reg <= SPAN_EVENT;
                    end
                    else
                    begin
                        from_reg <= in_freq;
                        to_reg   <= NS_PER_SEC;
                        span_reg <= SPAN_CLOCK;
                    end
                    if (in_gmult != '0)
                    begin
                        mult_reg  <= in_gmult;
                        shift_reg <= in_gshift;
                    end
                    else
                    begin
                        mult_reg  <= '0;
                        shift_reg <= '0;
                    end
                end
            end
            ST_HEAD:
            begin
                room_reg <= ROOM_MAX - SHIFT_W'(head_len);
            end
            ST_SRCH_WAIT:
            begin
                if (div_done)
                begin
                    if (srch_end)
                    begin
                        // no fit down to shift 1: keep that multiplier, shift 0
                        mult_reg  <= div_quot[WORD_W-1:0];
                        shift_reg <= fits ? s_reg : '0;
                    end
                    else
                        s_reg <= s_reg - MIN_SHIFT;
                end
            end
            ST_CAP_WAIT:
            begin
                if (div_done)
                    ticks_reg <= ticks_cap;
            end
            ST_MUL_LO:
            begin
                acc_reg <= mul_p;
            end
            ST_MUL_HI:
            begin
                hp_reg <= mul_p[WORD_W-1:0];
            end
            ST_NS_SUM:
            begin
                ns_reg <= (acc_reg + {hp_reg, {WORD_W{1'b0}}}) >> shift_reg;
            end
            ST_NSDIV_WAIT:
            begin
                if (div_done)
                    ns_reg <= div_quot;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {2'b00, ns_reg, ticks_reg, shift_reg, mult_reg};
                    m_tuser_reg <= (mult_reg == '0);
                end
            end
            default:
            begin
                m_tuser_reg <= m_tuser_reg;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hw/rtl/cms_checker.sv =====
`include "clock_mult_shift_calc_top_defines.svh"

module cms_checker
    import cms_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // stalled result holds
    `CMS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one request at a time: busy right after a request is taken
    `CMS_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)

    // bad flag tracks a zero multiplier
    `CMS_ASSERT(a_bad_flag, m_tvalid, m_tuser == (m_tdata[31:0] == '0))

    // bad result carries zero limits
    `CMS_ASSERT(a_bad_limits, m_tvalid && m_tuser, m_tdata[165:38] == '0)

    // a usable multiplier always allows at least one tick
    `CMS_ASSERT(a_tick_nonzero, m_tvalid && !m_tuser, m_tdata[101:38] != '0)

endmodule

bind clock_mult_shift_calc_top cms_checker u_cms_checker (.*);

// ===== tb/scale_checker.sv =====
`timescale 1ns / 100ps

module scale_checker
    import cms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    output int                   mismatches,
    output int                   awaiting
);

    localparam int REQ_W = 2 * WORD_W + SHIFT_W + DWORD_W;
    localparam int RES_W = WORD_W + SHIFT_W + 2 * DWORD_W;

    // Field order matches the bus packing, op / bad_mult on top from tuser.
    typedef struct packed {
        logic               op;
        logic [DWORD_W-1:0] tick_cap;
        logic [SHIFT_W-1:0] shift;
        logic [WORD_W-1:0]  mult;
        logic [WORD_W-1:0]  freq;
    } timer_req_t;

    typedef struct packed {
        logic               bad_mult;
        logic [DWORD_W-1:0] ns_limit;
        logic [DWORD_W-1:0] tick_limit;
        logic [SHIFT_W-1:0] scale_shift;
        logic [WORD_W-1:0]  scale_mult;
    } scale_t;

    scale_t expected_scales[$];
    int     fail_total = 0;
    int     queued = 0;

    assign mismatches = fail_total;
    assign awaiting   = queued;

    function automatic scale_t calc_scale(timer_req_t req);
        scale_t             r;
        logic [DWORD_W-1:0] from;
        logic [DWORD_W-1:0] to;
        logic [DWORD_W-1:0] span;
        logic [DWORD_W-1:0] head;
        logic [DWORD_W-1:0] m;
        logic [DWORD_W-1:0] cap;
        logic [DWORD_W-1:0] mult64;
        int                 room;
        int                 trial;
        r = '0;
        if (req.mult != 0)
        begin
            r.scale_mult  = req.mult;
            r.scale_shift = req.shift;
        end
        else if (req.op == OP_EVENT || req.freq != 0)
        begin
            if (req.op == OP_CLOCK)
            begin
                from = {32'd0, req.freq};
                to   = {32'd0, NS_PER_SEC};
                span = {54'd0, SPAN_CLOCK};
            end
            else
            begin
                from = {32'd0, NS_PER_SEC};
                to   = {32'd0, req.freq};
                span = {54'd0, SPAN_EVENT};
            end
            // headroom left in 32 bits after the span's worth of ticks
            head = (span * from) >> 32;
            room = 32;
            while (head != 0 && room > 0)
            begin
                head = head >> 1;
                room--;
            end
            m = 0;
            for (trial = MAX_SHIFT; trial > 0; trial--)
            begin
                m = ((to << trial) + (from >> 1)) / from;
                if ((m >> room) == 0)
                    break;
            end
            // no fit leaves shift 0 and the shift-1 multiplier
            r.scale_mult  = m[WORD_W-1:0];
            r.scale_shift = trial[SHIFT_W-1:0];
        end
        if (r.scale_mult != 0)
        begin
            mult64 = {32'd0, r.scale_mult};
            cap = {DWORD_W{1'b1}} / mult64;
            r.tick_limit = (req.tick_cap != 0 && req.tick_cap < cap) ? req.tick_cap : cap;
            if (req.op == OP_CLOCK)
                r.ns_limit = (r.tick_limit * mult64) >> r.scale_shift;
            else
                r.ns_limit = (r.tick_limit << r.scale_shift) / mult64;
        end
        r.bad_mult = (r.scale_mult == 0);
        return r;
    endfunction

    task automatic compare_field(string name, logic [DWORD_W-1:0] want,
                                 logic [DWORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        scale_t got;
        scale_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_scales.push_back(
                    calc_scale(timer_req_t'({s_tuser, s_tdata[REQ_W-1:0]})));
            if (m_tvalid && m_tready)
            begin
                got = scale_t'({m_tuser, m_tdata[RES_W-1:0]});
                if (expected_scales.size() == 0)
                begin
                    $error("result with no request outstanding: m_tdata %h", m_tdata);
                    fail_total++;
                end
                else
                begin
                    want = expected_scales.pop_front();
                    compare_field("scale_mult", want.scale_mult, got.scale_mult);
                    compare_field("scale_shift", want.scale_shift, got.scale_shift);
                    compare_field("tick_limit", want.tick_limit, got.tick_limit);
                    compare_field("ns_limit", want.ns_limit, got.ns_limit);
                    compare_field("bad_mult", want.bad_mult, got.bad_mult);
                end
            end
            queued = expected_scales.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import cms_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    int                   mismatches;
    int                   awaiting;
    bit                   no_idle = 1'b0;
    bit                   hold_off = 1'b0;

    clock_mult_shift_calc_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    scale_checker scale_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always #5 clk = ~clk;

    initial
    begin
        #(40_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off so that the
    // output register and the engine both fill and s_tready drops.
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (6000) @(negedge clk);
            end
            else
            begin
                m_tready <= no_idle || ($urandom_range(99) >= 18);
            end
        end
    end

    // Entered and left at a falling edge; valid stays high into the next request
    // unless that one starts with idle cycles.
    task automatic send_request(logic op, logic [WORD_W-1:0] freq, logic [WORD_W-1:0] gmult,
                                logic [SHIFT_W-1:0] gshift, logic [DWORD_W-1:0] gticks);
        while (!no_idle && $urandom_range(99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - 2 * WORD_W - SHIFT_W - DWORD_W){1'b0}},
                     gticks, gshift, gmult, freq};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic               op;
        logic [WORD_W-1:0]  freq;
        logic [WORD_W-1:0]  gmult;
        logic [SHIFT_W-1:0] gshift;
        logic [DWORD_W-1:0] gticks;
        int                 pick;
        int                 n;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // searched multipliers at the frequency extremes
        send_request(OP_CLOCK, 32'd1, 32'd0, 6'd0, 64'd0);
        send_request(OP_CLOCK, 32'hFFFF_FFFF, 32'd0, 6'd0, 64'd0);
        send_request(OP_EVENT, 32'd1, 32'd0, 6'd0, 64'd0);
        send_request(OP_EVENT, 32'hFFFF_FFFF, 32'd0, 6'd63, 64'd0);
        // zero frequency: no divisor for op 0, zero multiplier for op 1
        send_request(OP_CLOCK, 32'd0, 32'd0, 6'd0, 64'd100);
        send_request(OP_EVENT, 32'd0, 32'd0, 6'd0, 64'd100);
        // head crosses from zero to one bit here
        send_request(OP_CLOCK, 32'd7158278, 32'd0, 6'd0, 64'd0);
        send_request(OP_CLOCK, 32'd7158279, 32'd0, 6'd0, 64'd0);
        send_request(OP_CLOCK, 32'd32768, 32'd0, 6'd0, 64'h8000_0000_0000_0000);
        send_request(OP_CLOCK, 32'd1000000000, 32'd0, 6'd0, {DWORD_W{1'b1}});
        send_request(OP_EVENT, 32'd24000000, 32'd0, 6'd0, 64'd1);
        send_request(OP_EVENT, 32'd1000000000, 32'd0, 6'd0, 64'd12345);
        // given multipliers, shifts above 32 taken as they are
        send_request(OP_CLOCK, 32'd0, 32'hFFFF_FFFF, 6'd63, 64'd0);
        send_request(OP_CLOCK, 32'hFFFF_FFFF, 32'd1, 6'd32, 64'd5);
        send_request(OP_CLOCK, 32'd19200000, 32'h8000_0000, 6'd40, {DWORD_W{1'b1}});
        send_request(OP_EVENT, 32'd0, 32'd1, 6'd0, {DWORD_W{1'b1}});
        send_request(OP_EVENT, 32'd1, 32'd1, 6'd63, 64'd0);
        send_request(OP_EVENT, 32'd19200000, 32'd3, 6'd10, 64'd12345);
        send_request(OP_EVENT, 32'd1, 32'hFFFF_FFFF, 6'd0, 64'hFFFF_FFFF_FFFF_FFFE);

        hold_off = 1'b1;
        for (n = 0; n < 250; n++)
        begin
            no_idle = (n >= 120 && n < 170);
            op = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 4)
                freq = 32'd0;
            else if (pick < 30)
                freq = $urandom_range(1000, 1);
            else if (pick < 70)
                freq = $urandom_range(1000000000, 1000);
            else
                freq = $urandom;
            pick = $urandom_range(99);
            if (pick < 55)
                gmult = 32'd0;
            else if (pick < 60)
                gmult = 32'hFFFF_FFFF;
            else if (pick < 65)
                gmult = 32'd1;
            else
                gmult = $urandom;
            gshift = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(32));
            pick = $urandom_range(99);
            if (pick < 30)
                gticks = 64'd0;
            else if (pick < 60)
                gticks = {$urandom, $urandom};
            else if (pick < 90)
                gticks = 64'($urandom_range(1 << 20));
            else
                gticks = {DWORD_W{1'b1}};
            send_request(op, freq, gmult, gshift, gticks);
        end
        s_tvalid <= 1'b0;

        while (awaiting != 0)
            @(negedge clk);
        repeat (2500) @(negedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== clock_mult_shift_calc_top.f =====
+incdir+hw/rtl
hw/rtl/cms_pkg.sv
hw/rtl/cms_div.sv
hw/rtl/clock_mult_shift_calc_top.sv
hw/rtl/cms_checker.sv
tb/scale_checker.sv
tb/testbench.sv
